FILE: rtl/grvad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package grvad_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 10;
    localparam int FRAC_BITS    = 8;
    localparam int THR_W        = 16;
    localparam int LEVEL_W      = 16;
    // square of a clamped magnitude is at most 2^30
    localparam int SQ_W         = 31;
    // mean of squares never exceeds the largest square
    localparam int MEAN_W       = 31;
    localparam int SQRT_STEPS   = (MEAN_W + 1) / 2;
    localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);

    localparam int MAX_CHUNK_DEF     = 4096;
    localparam int HISTORY_DEPTH_DEF = 5;

    localparam int QUEUE_DEPTH  = 2;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIC_GAIN        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 1'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd655;

    // front to back: clamped magnitude, output bits, chunk end
    typedef struct packed {
        logic [SAMPLE_W-1:0]        omag;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       level_valid;
        logic [LEVEL_W-1:0]         rms_level;
        logic                       speech_active;
        logic                       voice_started;
        logic                       voice_stopped;
        logic                       chunk_overflow;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/grvad_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface grvad_in_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] sample_in;
    logic        last_in_chunk;

    modport source (output valid, output sample_in, output last_in_chunk, input ready);
    modport sink   (input valid, input sample_in, input last_in_chunk, output ready);
endinterface
`default_nettype wire

FILE: rtl/grvad_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface grvad_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] sample_out;
    logic        level_valid;
    logic [15:0] rms_level;
    logic        speech_active;
    logic        voice_started;
    logic        voice_stopped;
    logic        chunk_overflow;

    modport source (
        output valid, output sample_out, output level_valid, output rms_level,
        output speech_active, output voice_started, output voice_stopped,
        output chunk_overflow, input ready
    );
    modport sink (
        input valid, input sample_out, input level_valid, input rms_level,
        input speech_active, input voice_started, input voice_stopped,
        input chunk_overflow, output ready
    );
endinterface
`default_nettype wire

FILE: rtl/grvad_front.sv
`timescale 1ns / 1ps
`default_nettype none
module grvad_front (
    grvad_in_if.sink                         i_in_ch,
    input  wire [grvad_pkg::GAIN_W-1:0]      i_mic_gain,
    input  wire                              i_queue_full,
    output logic                             o_push,
    output grvad_pkg::t_item                 o_item
);

    localparam int MAG_W  = grvad_pkg::SAMPLE_W + 1;
    localparam int PROD_W = MAG_W + grvad_pkg::GAIN_W;
    localparam int Q_W    = PROD_W - grvad_pkg::FRAC_BITS;

    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    lim;
    logic [grvad_pkg::SAMPLE_W-1:0] omag;

    always_comb begin
        neg  = i_in_ch.sample_in[grvad_pkg::SAMPLE_W-1];
        // sign-extend then negate: magnitude up to 32768
        mag  = neg ? (MAG_W'(0) - {1'b1, i_in_ch.sample_in}) : {1'b0, i_in_ch.sample_in};
        prod = PROD_W'(mag) * PROD_W'(i_mic_gain);
        q    = prod[PROD_W-1:grvad_pkg::FRAC_BITS];
        lim  = neg ? Q_W'(32768) : Q_W'(32767);
        omag = (q > lim) ? lim[grvad_pkg::SAMPLE_W-1:0] : q[grvad_pkg::SAMPLE_W-1:0];
    end

    assign i_in_ch.ready     = !i_queue_full;
    assign o_push            = i_in_ch.valid && !i_queue_full;
    assign o_item.omag       = omag;
    assign o_item.sample_out = neg ? (grvad_pkg::SAMPLE_W'(0) - omag) : omag;
    assign o_item.last       = i_in_ch.last_in_chunk;

endmodule
`default_nettype wire

FILE: rtl/grvad_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module grvad_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  grvad_pkg::t_item  i_item,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_empty,
    output grvad_pkg::t_item  o_item
);

    localparam int DEPTH = grvad_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    grvad_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_item;
                r_wr        <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/grvad_back.sv
`timescale 1ns / 1ps
`default_nettype none
module grvad_back #(
    parameter int MAX_CHUNK     = grvad_pkg::MAX_CHUNK_DEF,
    parameter int HISTORY_DEPTH = grvad_pkg::HISTORY_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_empty,
    input  grvad_pkg::t_item             i_item,
    output logic                         o_pop,
    input  wire [grvad_pkg::THR_W-1:0]   i_level_thr,
    grvad_out_if.source                  o_out_ch
);

    localparam int SQ_W     = grvad_pkg::SQ_W;
    localparam int MEAN_W   = grvad_pkg::MEAN_W;
    localparam int LEVEL_W  = grvad_pkg::LEVEL_W;
    localparam int CNT_W    = $clog2(MAX_CHUNK + 1);
    localparam int SUM_W    = CNT_W + SQ_W - 1;
    localparam int DCNT_W   = $clog2(SUM_W);
    localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
    localparam int HSUM_W   = LEVEL_W + $clog2(HISTORY_DEPTH);
    localparam int CMP_W    = HSUM_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ACC, ST_DIV, ST_SQRT, ST_DEC, ST_EMIT
    } t_state;

    t_state                r_state;
    logic [SQ_W-1:0]       r_sq;
    logic signed [grvad_pkg::SAMPLE_W-1:0] r_bits;
    logic                  r_last;
    logic [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_count;
    logic                  r_ovf;
    // divider
    logic [SUM_W-1:0]      r_dvd;
    logic [CNT_W-1:0]      r_dvs;
    logic [CNT_W-1:0]      r_rem;
    logic [DCNT_W-1:0]     r_div_cnt;
    // root
    logic [MEAN_W-1:0]     r_sv;
    logic [MEAN_W-1:0]     r_root;
    logic [MEAN_W-1:0]     r_bit;
    logic [grvad_pkg::SQRT_CNT_W-1:0] r_sqrt_cnt;
    // decision
    logic [LEVEL_W-1:0]    r_hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0]     r_slot;
    logic [HSUM_W-1:0]     r_hsum;
    logic                  r_voice;
    grvad_pkg::t_result    r_res;
    grvad_pkg::t_result    r_out;
    logic                  r_out_valid;

    logic                  out_free;
    logic                  out_load;
    logic                  room;
    logic                  ovf_now;
    logic [SUM_W-1:0]      n_sum;
    logic [CNT_W-1:0]      n_count;
    grvad_pkg::t_result    n_res;
    logic [CNT_W:0]        rem_sh;
    logic                  div_ge;
    logic [CNT_W:0]        rem_diff;
    logic [CNT_W-1:0]      n_rem;
    logic [SUM_W-1:0]      n_dvd;
    logic [MEAN_W:0]       trial;
    logic                  sq_ge;
    logic [MEAN_W-1:0]     n_sv;
    logic [MEAN_W-1:0]     n_root;
    logic [LEVEL_W-1:0]    level;
    logic [HSUM_W-1:0]     n_hsum;
    logic [CMP_W-1:0]      lhs;
    logic [CMP_W-1:0]      rhs;
    logic                  now;
    logic [SLOT_W-1:0]     n_slot;

    assign out_free = !r_out_valid || o_out_ch.ready;
    assign out_load = out_free &&
                      (((r_state == ST_ACC) && !r_last) || (r_state == ST_EMIT));
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        // accumulate, saturating once the chunk is full
        room    = (r_count < CNT_W'(MAX_CHUNK));
        ovf_now = r_ovf || !room;
        n_sum   = room ? (r_sum + SUM_W'(r_sq)) : r_sum;
        n_count = room ? (r_count + 1'b1) : r_count;

        n_res                = '0;
        n_res.sample_out     = r_bits;
        n_res.speech_active  = r_voice;
        n_res.chunk_overflow = ovf_now;

        // restoring divide, one quotient bit a cycle
        rem_sh   = {r_rem, r_dvd[SUM_W-1]};
        div_ge   = (rem_sh >= {1'b0, r_dvs});
        rem_diff = rem_sh - {1'b0, r_dvs};
        n_rem    = div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        n_dvd    = {r_dvd[SUM_W-2:0], div_ge};

        // digit-by-digit square root, two radicand bits a cycle
        trial  = {1'b0, r_root} + {1'b0, r_bit};
        sq_ge  = ({1'b0, r_sv} >= trial);
        n_sv   = sq_ge ? (r_sv - trial[MEAN_W-1:0]) : r_sv;
        n_root = sq_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);

        // running history sum: drop the entry being overwritten
        level  = r_root[LEVEL_W-1:0];
        n_hsum = r_hsum - HSUM_W'(r_hist[r_slot]) + HSUM_W'(level);
        lhs    = CMP_W'(level) * CMP_W'(HISTORY_DEPTH);
        rhs    = {1'b0, n_hsum, 1'b0};
        now    = (level > i_level_thr) && (lhs > rhs);
        n_slot = (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_slot      <= '0;
            r_hsum      <= '0;
            r_voice     <= 1'b0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_sq    <= SQ_W'(32'(i_item.omag) * 32'(i_item.omag));
                        r_bits  <= i_item.sample_out;
                        r_last  <= i_item.last;
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (r_last) begin
                        r_dvd     <= n_sum;
                        r_dvs     <= n_count;
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_sum     <= '0;
                        r_count   <= '0;
                        r_ovf     <= 1'b0;
                        r_res     <= n_res;
                        r_state   <= ST_DIV;
                    end else begin
                        r_sum   <= n_sum;
                        r_count <= n_count;
                        r_ovf   <= ovf_now;
                        if (out_free) begin
                            r_out   <= n_res;
                            r_state <= ST_IDLE;
                        end else begin
                            r_res   <= n_res;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem     <= n_rem;
                    r_dvd     <= n_dvd;
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DCNT_W'(SUM_W - 1)) begin
                        // mean never exceeds the largest square
                        r_sv       <= n_dvd[MEAN_W-1:0];
                        r_root     <= '0;
                        r_bit      <= MEAN_W'(1) << (MEAN_W - 1);
                        r_sqrt_cnt <= '0;
                        r_state    <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_sv       <= n_sv;
                    r_root     <= n_root;
                    r_bit      <= r_bit >> 2;
                    r_sqrt_cnt <= r_sqrt_cnt + 1'b1;
                    if (r_sqrt_cnt == grvad_pkg::SQRT_CNT_W'(grvad_pkg::SQRT_STEPS - 1)) begin
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_hist[r_slot]      <= level;
                    r_slot              <= n_slot;
                    r_hsum              <= n_hsum;
                    r_voice             <= now;
                    r_res.level_valid   <= 1'b1;
                    r_res.rms_level     <= level;
                    r_res.speech_active <= now;
                    r_res.voice_started <= now && !r_voice;
                    r_res.voice_stopped <= !now && r_voice;
                    r_state             <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.sample_out     = r_out.sample_out;
    assign o_out_ch.level_valid    = r_out.level_valid;
    assign o_out_ch.rms_level      = r_out.rms_level;
    assign o_out_ch.speech_active  = r_out.speech_active;
    assign o_out_ch.voice_started  = r_out.voice_started;
    assign o_out_ch.voice_stopped  = r_out.voice_stopped;
    assign o_out_ch.chunk_overflow = r_out.chunk_overflow;

endmodule
`default_nettype wire

FILE: rtl/gain_rms_voice_activity_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Gain stage and energy-based voice activity detector. Every sample transfer on
// i_in_ch gives exactly one result transfer on o_out_ch, in order: the sample
// times mic_gain (unsigned Q2.8), truncated toward zero and clamped to 16 bits.
// The squares are summed over a chunk; the result of a chunk's last sample also
// carries the rms level (floor of the root of the floored mean, 32768 = full
// scale) and the voice decision, which needs the level above level_threshold
// and HISTORY_DEPTH times the level above twice the sum of the last
// HISTORY_DEPTH levels. Samples past MAX_CHUNK are passed on but not summed,
// and chunk_overflow is shown for the rest of that chunk. In the back end an
// ordinary sample is dequeued and squared, then accumulated. A chunk's last
// sample also passes through the bit-serial divider, over SUM_W =
// clog2(MAX_CHUNK+1) + 30 dividend bits, and the two-bits-a-cycle square root;
// a two-entry queue takes the next two samples meanwhile, after which the input
// stalls. Configuration is written through i_cfg_we, i_cfg_idx (0 gain,
// 1 threshold) and i_cfg_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module gain_rms_voice_activity_detector #(
    parameter int MAX_CHUNK     = grvad_pkg::MAX_CHUNK_DEF,
    parameter int HISTORY_DEPTH = grvad_pkg::HISTORY_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    grvad_in_if.sink                            i_in_ch,
    grvad_out_if.source                         o_out_ch,
    input  wire                                 i_cfg_we,
    input  wire [grvad_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [grvad_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [grvad_pkg::GAIN_W-1:0] r_mic_gain;
    logic [grvad_pkg::THR_W-1:0]  r_level_thr;

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    grvad_pkg::t_item front_item;
    grvad_pkg::t_item back_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mic_gain  <= grvad_pkg::GAIN_RESET;
            r_level_thr <= grvad_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grvad_pkg::CFG_MIC_GAIN:
                    r_mic_gain <= i_cfg_data[grvad_pkg::GAIN_W-1:0];
                grvad_pkg::CFG_LEVEL_THRESHOLD:
                    r_level_thr <= i_cfg_data[grvad_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    grvad_front u_front (
        .i_in_ch      (i_in_ch),
        .i_mic_gain   (r_mic_gain),
        .i_queue_full (full),
        .o_push       (push),
        .o_item       (front_item)
    );

    grvad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (back_item)
    );

    grvad_back #(
        .MAX_CHUNK     (MAX_CHUNK),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_item      (back_item),
        .o_pop       (pop),
        .i_level_thr (r_level_thr),
        .o_out_ch    (o_out_ch)
    );

endmodule
`default_nettype wire
